[hw/rtl/ecsr_pkg.sv]
// ----------------------------------------------------------------------------
// ecsr_pkg
// Shared types, codes and default sizes of the edge-list to CSR builder.
// ----------------------------------------------------------------------------
package ecsr_pkg;

    // Default store sizes.
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;

    // Function codes of a request.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result regions.
    localparam logic [2:0] RG_OFFSET   = 3'd0;
    localparam logic [2:0] RG_NEIGHBOR = 3'd1;
    localparam logic [2:0] RG_PAIR_SRC = 3'd2;
    localparam logic [2:0] RG_PAIR_DST = 3'd3;
    localparam logic [2:0] RG_ROOT     = 3'd4;
    localparam logic [2:0] RG_PAIR_CNT = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_BAD_EDGE  = 2'd3;

    // Register index, taken from byte address bit 2.
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_EDGE_COUNT   = 1'b1;

    // One request.
    typedef struct packed {
        logic        func;
        logic [9:0]  src_vertex;
        logic [9:0]  dst_vertex;
        logic [2:0]  read_region;
        logic [11:0] read_index;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic [2:0]  region;
        logic [11:0] entry_index;
        logic [12:0] value;
        logic [1:0]  status;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_READ,
        S_PFX,
        S_SC_E,
        S_SC_F,
        S_SC_W,
        S_PR_OFF,
        S_PR_OFFW,
        S_PR_NB,
        S_PR_NBW
    } t_state;

endpackage

[hw/rtl/ecsr_ram.sv]
// ----------------------------------------------------------------------------
// ecsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ecsr_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/edge_list_to_csr_builder_unit.sv]
// A load request reads the source degree, then writes it back incremented; a
// read request gives its result strobe in the cycle after it is accepted. The
// build after the last edge runs over the degree, offset, edge, neighbor and pair
// RAMs with busy high. After reset and after every register write a clearing
// pass zeroes the degree RAM while busy is high. Results cannot be stalled.
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_unit
// Loads directed edges, counts out-degrees, builds CSR offsets and neighbors,
// finds the root and the ordered pairs, and answers read requests.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder_unit #(
    parameter int MAX_VERTICES = ecsr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ecsr_pkg::MAX_EDGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ecsr_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output ecsr_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import ecsr_pkg::*;

    localparam int VAW  = $clog2(MAX_VERTICES);
    localparam int VCW  = $clog2(MAX_VERTICES + 1);
    localparam int OAW  = VCW;
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int PCAP = MAX_EDGES / 2;
    localparam int PAW  = (PCAP > 1) ? $clog2(PCAP) : 1;
    localparam int PTW  = $clog2(PCAP + 1);

    // Registers.
    t_state           r_state, n_state;
    logic [10:0]      r_vc, n_vc;
    logic [12:0]      r_ec, n_ec;
    logic [CW-1:0]    r_edges, n_edges;
    logic [PTW-1:0]   r_ptotal, n_ptotal;
    logic [VAW-1:0]   r_root, n_root;
    logic [CW-1:0]    r_best, n_best;
    logic             r_built, n_built;
    logic             r_bad, n_bad;
    logic [VCW-1:0]   r_vcnt, n_vcnt;
    logic [CW-1:0]    r_ecnt, n_ecnt;
    logic             r_pv, n_pv;
    logic [CW-1:0]    r_acc, n_acc;
    logic [VAW-1:0]   r_u, n_u;
    logic [VAW-1:0]   r_v, n_v;
    logic [CW-1:0]    r_end, n_end;
    logic [2:0]       r_rreg, n_rreg;
    logic [11:0]      r_ridx, n_ridx;
    logic [1:0]       r_rst, n_rst;

    // RAM ports.
    logic             deg_we;
    logic [VAW-1:0]   deg_waddr, deg_raddr;
    logic [CW-1:0]    deg_wdata, deg_rdata;
    logic             off_we;
    logic [OAW-1:0]   off_waddr, off_raddr;
    logic [CW-1:0]    off_wdata, off_rdata;
    logic             edge_we;
    logic [EAW-1:0]   edge_waddr, edge_raddr;
    logic [2*VAW-1:0] edge_wdata, edge_rdata;
    logic             nb_we;
    logic [EAW-1:0]   nb_waddr, nb_raddr;
    logic [VAW-1:0]   nb_wdata, nb_rdata;
    logic             pair_we;
    logic [PAW-1:0]   pair_waddr, pair_raddr;
    logic [2*VAW-1:0] pair_wdata, pair_rdata;

    // Shared conditions.
    logic             cfg_we;
    logic             accept;
    logic [VCW-1:0]   w_nv;
    logic [CW-1:0]    w_ne;
    logic             w_edge_bad;
    logic             w_clr_last;
    logic             w_load_last;
    logic             w_pfx_fin;
    logic             w_sc_last;
    logic             w_nb_more;
    logic             w_pr_last;
    logic [VCW-1:0]   w_vprev;
    logic [12:0]      w_value;

    // Register write and read access.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_EDGE_COUNT) ? 32'(r_ec) : 32'(r_vc);

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Effective vertex and edge counts, saturated into their ranges.
    always_comb begin
        if (r_vc == 11'd0) begin
            w_nv = VCW'(1);
        end else if (32'(r_vc) > MAX_VERTICES) begin
            w_nv = VCW'(MAX_VERTICES);
        end else begin
            w_nv = VCW'(r_vc);
        end
        if (r_ec == 13'd0) begin
            w_ne = CW'(1);
        end else if (32'(r_ec) > MAX_EDGES) begin
            w_ne = CW'(MAX_EDGES);
        end else begin
            w_ne = CW'(r_ec);
        end
    end

    assign w_edge_bad  = (32'(i_cmd.src_vertex) >= 32'(w_nv)) ||
                         (32'(i_cmd.dst_vertex) >= 32'(w_nv));
    assign w_clr_last  = (32'(r_vcnt) == MAX_VERTICES - 1);
    assign w_load_last = (32'(r_edges) + 1 >= 32'(w_ne));
    assign w_pfx_fin   = (r_vcnt == w_nv) && !r_pv;
    assign w_sc_last   = (32'(r_ecnt) + 1 >= 32'(r_edges));
    assign w_nb_more   = (r_ecnt < r_end);
    assign w_pr_last   = (32'(r_vcnt) + 1 >= 32'(w_nv));
    assign w_vprev     = r_vcnt - VCW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        if (cfg_we) begin
            n_state = S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (w_clr_last) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd.func == FUNC_READ) begin
                            n_state = S_READ;
                        end else if (!r_built && !w_edge_bad) begin
                            n_state = S_LOAD;
                        end
                    end
                end
                S_LOAD:    n_state = w_load_last ? S_PFX : S_IDLE;
                S_READ:    n_state = S_IDLE;
                S_PFX: begin
                    if (w_pfx_fin) n_state = S_SC_E;
                end
                S_SC_E:    n_state = S_SC_F;
                S_SC_F:    n_state = S_SC_W;
                S_SC_W:    n_state = w_sc_last ? S_PR_OFF : S_SC_E;
                S_PR_OFF:  n_state = S_PR_OFFW;
                S_PR_OFFW: n_state = S_PR_NB;
                S_PR_NB: begin
                    if (w_nb_more) begin
                        n_state = S_PR_NBW;
                    end else begin
                        n_state = w_pr_last ? S_IDLE : S_PR_OFF;
                    end
                end
                S_PR_NBW:  n_state = S_PR_NB;
                default:   n_state = S_IDLE;
            endcase
        end
    end

    // Datapath: RAM accesses and register updates of each state.
    always_comb begin
        n_vc     = r_vc;
        n_ec     = r_ec;
        n_edges  = r_edges;
        n_ptotal = r_ptotal;
        n_root   = r_root;
        n_best   = r_best;
        n_built  = r_built;
        n_bad    = r_bad;
        n_vcnt   = r_vcnt;
        n_ecnt   = r_ecnt;
        n_pv     = r_pv;
        n_acc    = r_acc;
        n_u      = r_u;
        n_v      = r_v;
        n_end    = r_end;
        n_rreg   = r_rreg;
        n_ridx   = r_ridx;
        n_rst    = r_rst;

        deg_we     = 1'b0;
        deg_waddr  = '0;
        deg_wdata  = '0;
        deg_raddr  = '0;
        off_we     = 1'b0;
        off_waddr  = '0;
        off_wdata  = '0;
        off_raddr  = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        nb_we      = 1'b0;
        nb_waddr   = '0;
        nb_wdata   = '0;
        nb_raddr   = '0;
        pair_we    = 1'b0;
        pair_waddr = '0;
        pair_wdata = '0;
        pair_raddr = '0;

        unique case (r_state)
            // Zero one degree entry per cycle.
            S_CLEAR: begin
                deg_we    = 1'b1;
                deg_waddr = VAW'(r_vcnt);
                n_vcnt    = r_vcnt + VCW'(1);
            end

            // Take a request: store the edge and fetch its source degree,
            // or look up a result entry.
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.func == FUNC_LOAD) begin
                        if (!r_built) begin
                            if (w_edge_bad) begin
                                n_bad = 1'b1;
                            end else begin
                                edge_we    = 1'b1;
                                edge_waddr = EAW'(r_edges);
                                edge_wdata = {VAW'(i_cmd.src_vertex),
                                              VAW'(i_cmd.dst_vertex)};
                                deg_raddr  = VAW'(i_cmd.src_vertex);
                                n_u        = VAW'(i_cmd.src_vertex);
                            end
                        end
                    end else begin
                        n_rreg     = i_cmd.read_region;
                        n_ridx     = i_cmd.read_index;
                        off_raddr  = OAW'(i_cmd.read_index);
                        nb_raddr   = EAW'(i_cmd.read_index);
                        pair_raddr = PAW'(i_cmd.read_index);
                        n_rst      = ST_OK;
                        if (r_bad) begin
                            n_rst = ST_BAD_EDGE;
                        end else if (!r_built) begin
                            n_rst = ST_NOT_BUILT;
                        end else begin
                            unique case (i_cmd.read_region)
                                RG_OFFSET: begin
                                    if (32'(i_cmd.read_index) > 32'(w_nv)) n_rst = ST_RANGE;
                                end
                                RG_NEIGHBOR: begin
                                    if (32'(i_cmd.read_index) >= 32'(r_edges)) n_rst = ST_RANGE;
                                end
                                RG_PAIR_SRC, RG_PAIR_DST: begin
                                    if (32'(i_cmd.read_index) >= 32'(r_ptotal)) n_rst = ST_RANGE;
                                end
                                RG_ROOT, RG_PAIR_CNT: n_rst = ST_OK;
                                default: n_rst = ST_RANGE;
                            endcase
                        end
                    end
                end
            end

            // Write back the incremented degree; start the build after the last edge.
            S_LOAD: begin
                deg_we    = 1'b1;
                deg_waddr = r_u;
                deg_wdata = deg_rdata + CW'(1);
                n_edges   = r_edges + CW'(1);
                if (w_load_last) begin
                    n_vcnt = '0;
                    n_pv   = 1'b0;
                    n_acc  = '0;
                    n_best = '0;
                    n_root = '0;
                end
            end

            S_READ: begin
            end

            // Prefix sum: one degree read per cycle, offset and fill pointer
            // written in the cycle after the read; the root is tracked on the way.
            S_PFX: begin
                if (r_vcnt < w_nv) begin
                    deg_raddr = VAW'(r_vcnt);
                    n_vcnt    = r_vcnt + VCW'(1);
                    n_pv      = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    off_we    = 1'b1;
                    off_waddr = OAW'(w_vprev);
                    off_wdata = r_acc;
                    deg_we    = 1'b1;
                    deg_waddr = VAW'(w_vprev);
                    deg_wdata = r_acc;
                    n_acc     = r_acc + deg_rdata;
                    if (deg_rdata > r_best) begin
                        n_best = deg_rdata;
                        n_root = VAW'(w_vprev);
                    end
                end
                if (w_pfx_fin) begin
                    off_we    = 1'b1;
                    off_waddr = OAW'(w_nv);
                    off_wdata = r_acc;
                    n_ecnt    = '0;
                end
            end

            // Scatter: fetch an edge, fetch its fill pointer, place the neighbor.
            S_SC_E: begin
                edge_raddr = EAW'(r_ecnt);
            end
            S_SC_F: begin
                n_u       = edge_rdata[2*VAW-1:VAW];
                n_v       = edge_rdata[VAW-1:0];
                deg_raddr = edge_rdata[2*VAW-1:VAW];
            end
            S_SC_W: begin
                deg_we    = 1'b1;
                deg_waddr = r_u;
                deg_wdata = deg_rdata + CW'(1);
                nb_we     = 1'b1;
                nb_waddr  = EAW'(deg_rdata);
                nb_wdata  = r_v;
                n_ecnt    = r_ecnt + CW'(1);
                if (w_sc_last) begin
                    n_vcnt   = '0;
                    n_ecnt   = '0;
                    n_ptotal = '0;
                end
            end

            // Pair walk: fetch the end offset of a vertex, then its neighbors.
            S_PR_OFF: begin
                off_raddr = OAW'(r_vcnt + VCW'(1));
            end
            S_PR_OFFW: begin
                n_end = off_rdata;
            end
            S_PR_NB: begin
                if (w_nb_more) begin
                    nb_raddr = EAW'(r_ecnt);
                end else begin
                    n_vcnt = r_vcnt + VCW'(1);
                    if (w_pr_last) n_built = 1'b1;
                end
            end
            S_PR_NBW: begin
                n_ecnt = r_ecnt + CW'(1);
                if ((32'(r_vcnt) < 32'(nb_rdata)) && (32'(r_ptotal) < PCAP)) begin
                    pair_we    = 1'b1;
                    pair_waddr = PAW'(r_ptotal);
                    pair_wdata = {VAW'(r_vcnt), nb_rdata};
                    n_ptotal   = r_ptotal + PTW'(1);
                end
            end

            default: begin
            end
        endcase

        // A register write clears the block and restarts loading.
        if (cfg_we) begin
            if (paddr[2] == REG_VERTEX_COUNT) begin
                n_vc = pwdata[10:0];
            end else begin
                n_ec = pwdata[12:0];
            end
            n_edges  = '0;
            n_ptotal = '0;
            n_root   = '0;
            n_best   = '0;
            n_built  = 1'b0;
            n_bad    = 1'b0;
            n_vcnt   = '0;
        end
    end

    // Result outputs.
    always_comb begin
        unique case (r_rreg)
            RG_OFFSET:   w_value = 13'(32'(off_rdata));
            RG_NEIGHBOR: w_value = 13'(32'(nb_rdata));
            RG_PAIR_SRC: w_value = 13'(32'(pair_rdata[2*VAW-1:VAW]));
            RG_PAIR_DST: w_value = 13'(32'(pair_rdata[VAW-1:0]));
            RG_ROOT:     w_value = 13'(32'(r_root));
            RG_PAIR_CNT: w_value = 13'(32'(r_ptotal));
            default:     w_value = '0;
        endcase
        o_valid              = (r_state == S_READ);
        o_result.region      = r_rreg;
        o_result.entry_index = r_ridx;
        o_result.status      = r_rst;
        o_result.value       = (r_rst == ST_OK) ? w_value : 13'd0;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_vc     <= 11'd1;
            r_ec     <= 13'd1;
            r_edges  <= '0;
            r_ptotal <= '0;
            r_root   <= '0;
            r_best   <= '0;
            r_built  <= 1'b0;
            r_bad    <= 1'b0;
            r_vcnt   <= '0;
            r_ecnt   <= '0;
            r_pv     <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_state  <= n_state;
            r_vc     <= n_vc;
            r_ec     <= n_ec;
            r_edges  <= n_edges;
            r_ptotal <= n_ptotal;
            r_root   <= n_root;
            r_best   <= n_best;
            r_built  <= n_built;
            r_bad    <= n_bad;
            r_vcnt   <= n_vcnt;
            r_ecnt   <= n_ecnt;
            r_pv     <= n_pv;
            r_acc    <= n_acc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_v    <= n_v;
        r_end  <= n_end;
        r_rreg <= n_rreg;
        r_ridx <= n_ridx;
        r_rst  <= n_rst;
    end

    // Degree counts, reused as fill pointers during the scatter.
    ecsr_ram #(.W(CW), .D(MAX_VERTICES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    // CSR offsets.
    ecsr_ram #(.W(CW), .D(MAX_VERTICES + 1)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    // Loaded edges, source and destination side by side.
    ecsr_ram #(.W(2 * VAW), .D(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    // CSR neighbors.
    ecsr_ram #(.W(VAW), .D(MAX_EDGES)) u_nb_ram (
        .i_clk   (i_clk),
        .i_we    (nb_we),
        .i_waddr (nb_waddr),
        .i_wdata (nb_wdata),
        .i_raddr (nb_raddr),
        .o_rdata (nb_rdata)
    );

    // Ordered pairs, source and destination side by side.
    ecsr_ram #(.W(2 * VAW), .D(PCAP)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (pair_raddr),
        .o_rdata (pair_rdata)
    );

    // A read request yields a result in the next cycle unless a register write
    // restarts the block.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.func == FUNC_READ) && !cfg_we) |=> o_valid)
        else $error("read request gave no result");

    // A result with a non-ok status carries a zero value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != ST_OK)) |-> (o_result.value == 13'd0))
        else $error("value not zero on error status");

    // The edge count never passes the edge store depth.
    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edges) <= MAX_EDGES)
        else $error("edge count beyond store depth");

    // The pair count never passes its cap.
    a_pairs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptotal) <= PCAP)
        else $error("pair count beyond cap");

endmodule

[test/edge_list_to_csr_builder_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_unit_test
// Loads edge lists under several vertex and edge counts and checks every read
// against an in-bench CSR builder that tracks degrees, offsets, neighbors,
// root and ordered pairs. A directed table comes first, then random phases.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder_unit_test;
    import ecsr_pkg::*;

    localparam int NV_MAX   = 1024;
    localparam int NE_MAX   = 4096;
    localparam int PAIR_CAP = NE_MAX / 2;
    localparam int WATCHDOG = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        cmd;
    logic        o_valid;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    edge_list_to_csr_builder_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the builder state.
    bit [10:0] vtx_reg;
    bit [12:0] edge_reg;
    bit [12:0] degree[NV_MAX];
    bit [12:0] offsets[NV_MAX + 1];
    bit [12:0] fill_ptr[NV_MAX];
    bit [9:0]  edge_src[NE_MAX];
    bit [9:0]  edge_dst[NE_MAX];
    bit [9:0]  nbr[NE_MAX];
    bit [9:0]  pair_src[PAIR_CAP];
    bit [9:0]  pair_dst[PAIR_CAP];
    int        loaded;
    int        pair_total;
    int        root;
    bit        built;
    bit        bad_seen;

    t_result   pending_reads[$];
    int        errors;
    int        idle_cycles;
    int        loads_sent;
    int        reads_sent;
    int        phases_run;
    int        idle_pct;

    // Directed stimulus table.
    typedef struct {
        bit        is_cfg;
        bit        cfg_reg;
        bit [31:0] cfg_val;
        t_cmd      c;
        bit        chk;
        t_result   exp;
    } t_step;
    t_step steps[$];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void add_step(input t_step s);
        steps.insert(steps.size(), s);
    endfunction

    function automatic int eff_vertices();
        if (vtx_reg < 1) return 1;
        if (vtx_reg > NV_MAX) return NV_MAX;
        return int'(vtx_reg);
    endfunction

    function automatic int eff_edges();
        if (edge_reg < 1) return 1;
        if (edge_reg > NE_MAX) return NE_MAX;
        return int'(edge_reg);
    endfunction

    function automatic void clear_graph();
        foreach (degree[i]) degree[i] = '0;
        loaded     = 0;
        pair_total = 0;
        root       = 0;
        built      = 1'b0;
        bad_seen   = 1'b0;
    endfunction

    // Prefix sum, scatter in load order, root search and pair listing.
    function automatic void build_graph();
        int nv;
        int best;
        int u;
        int slot;
        nv = eff_vertices();
        offsets[0] = '0;
        for (int i = 0; i < nv; i++) begin
            offsets[i + 1] = offsets[i] + degree[i];
            fill_ptr[i]    = offsets[i];
        end
        for (int i = 0; i < loaded; i++) begin
            u = int'(edge_src[i]);
            slot = int'(fill_ptr[u]);
            fill_ptr[u] = 13'(slot + 1);
            if (slot < NE_MAX) nbr[slot] = edge_dst[i];
        end
        root = 0;
        best = 0;
        pair_total = 0;
        for (int i = 0; i < nv; i++) begin
            if (int'(degree[i]) > best) begin
                best = int'(degree[i]);
                root = i;
            end
            for (int j = int'(offsets[i]); j < int'(offsets[i + 1]) && j < NE_MAX; j++) begin
                if (i < int'(nbr[j]) && pair_total < PAIR_CAP) begin
                    pair_src[pair_total] = 10'(i);
                    pair_dst[pair_total] = nbr[j];
                    pair_total++;
                end
            end
        end
        built = 1'b1;
    endfunction

    // Applies one accepted request; returns 1 when it yields a result.
    function automatic bit csr_apply(input t_cmd c, output t_result r);
        int nv;
        int idx;
        r = '0;
        if (c.func == FUNC_LOAD) begin
            nv = eff_vertices();
            if (built) return 1'b0;
            if (int'(c.src_vertex) >= nv || int'(c.dst_vertex) >= nv) begin
                bad_seen = 1'b1;
                return 1'b0;
            end
            if (loaded < NE_MAX) begin
                edge_src[loaded] = c.src_vertex;
                edge_dst[loaded] = c.dst_vertex;
                loaded++;
                degree[c.src_vertex]++;
            end
            if (loaded >= eff_edges()) build_graph();
            return 1'b0;
        end
        idx = int'(c.read_index);
        r.region      = c.read_region;
        r.entry_index = c.read_index;
        r.status      = ST_OK;
        if (bad_seen) begin
            r.status = ST_BAD_EDGE;
        end else if (!built) begin
            r.status = ST_NOT_BUILT;
        end else begin
            case (c.read_region)
                RG_OFFSET: begin
                    if (idx <= eff_vertices()) r.value = offsets[idx];
                    else r.status = ST_RANGE;
                end
                RG_NEIGHBOR: begin
                    if (idx < loaded) r.value = 13'(nbr[idx]);
                    else r.status = ST_RANGE;
                end
                RG_PAIR_SRC: begin
                    if (idx < pair_total) r.value = 13'(pair_src[idx]);
                    else r.status = ST_RANGE;
                end
                RG_PAIR_DST: begin
                    if (idx < pair_total) r.value = 13'(pair_dst[idx]);
                    else r.status = ST_RANGE;
                end
                RG_ROOT:     r.value = 13'(root);
                RG_PAIR_CNT: r.value = 13'(pair_total);
                default:     r.status = ST_RANGE;
            endcase
        end
        return 1'b1;
    endfunction

    function automatic t_cmd load_cmd(input int s, input int d);
        t_cmd c;
        c = '0;
        c.func = FUNC_LOAD;
        c.src_vertex = 10'(s);
        c.dst_vertex = 10'(d);
        return c;
    endfunction

    function automatic t_cmd read_cmd(input logic [2:0] rg, input int idx);
        t_cmd c;
        c = '0;
        c.func = FUNC_READ;
        c.read_region = rg;
        c.read_index = 12'(idx);
        return c;
    endfunction

    function automatic t_result mk_result(input logic [2:0] rg, input int idx,
                                          input int val, input logic [1:0] st);
        t_result r;
        r.region = rg;
        r.entry_index = 12'(idx);
        r.value = 13'(val);
        r.status = st;
        return r;
    endfunction

    // Waits until the block is idle with no result outstanding.
    task automatic wait_drained();
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input bit which, input bit [31:0] data);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= (which == REG_EDGE_COUNT) ? 3'd4 : 3'd0;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_EDGE_COUNT) edge_reg = data[12:0];
        else vtx_reg = data[10:0];
        clear_graph();
    endtask

    // Presents one request and holds it until the block takes it.
    task automatic send_request(input t_cmd c, input bit chk, input t_result exp);
        t_result r;
        bit has;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy);
        has = csr_apply(c, r);
        if (has) begin
            pending_reads.insert(pending_reads.size(), chk ? exp : r);
            reads_sent++;
        end else begin
            loads_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send(input t_cmd c);
        send_request(c, 1'b0, '0);
    endtask

    // Read with an index mostly inside the region's valid range.
    function automatic t_cmd random_read();
        logic [2:0] rg;
        int lim;
        rg = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5, 0));
        case (rg)
            RG_OFFSET:   lim = eff_vertices();
            RG_NEIGHBOR: lim = loaded - 1;
            RG_PAIR_SRC, RG_PAIR_DST: lim = pair_total - 1;
            default:     lim = 0;
        endcase
        if (lim < 0 || $urandom_range(9, 0) < 2) return read_cmd(rg, $urandom_range(4095, 0));
        return read_cmd(rg, $urandom_range(lim, 0));
    endfunction

    // One random phase: configure, load the edge list, then read results back.
    // asc_pct is the share of edges drawn with source below destination.
    task automatic run_phase(input int vc, input int ec, input bit allow_bad,
                             input int asc_pct);
        int nv;
        int s;
        int d;
        write_reg(REG_VERTEX_COUNT, 32'(vc));
        write_reg(REG_EDGE_COUNT, 32'(ec));
        nv = eff_vertices();
        while (!built) begin
            if ($urandom_range(9, 0) == 0) begin
                send(random_read());
            end else begin
                if (nv > 1 && $urandom_range(99, 0) < asc_pct) begin
                    s = $urandom_range(nv - 2, 0);
                    d = $urandom_range(nv - 1, s + 1);
                end else begin
                    s = $urandom_range(nv - 1, 0);
                    d = $urandom_range(nv - 1, 0);
                end
                if (allow_bad && $urandom_range(29, 0) == 0) s = $urandom_range(1023, 0);
                if (allow_bad && $urandom_range(29, 0) == 0) d = $urandom_range(1023, 0);
                send(load_cmd(s, d));
            end
            // After a bad edge every read reports a bad edge, so the phase may stop early.
            if (bad_seen && $urandom_range(19, 0) == 0) break;
        end
        send(load_cmd($urandom_range(1023, 0), $urandom_range(1023, 0)));
        repeat ($urandom_range(40, 15)) send(random_read());
        phases_run++;
    endtask

    // A phase with random register values, mostly small graphs.
    task automatic random_phase();
        int vc;
        int ec;
        case ($urandom_range(7, 0))
            0:       vc = 0;
            1:       vc = ($urandom_range(1, 0) != 0) ? 1024 : 2047;
            default: vc = $urandom_range(12, 1);
        endcase
        ec = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(30, 1);
        run_phase(vc, ec, $urandom_range(3, 0) == 0,
                  ($urandom_range(1, 0) != 0) ? 80 : 0);
        start <= 1'b0;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_reads.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_result);
            end else begin
                want = pending_reads.pop_front();
                if (o_result.region !== want.region ||
                    o_result.entry_index !== want.entry_index ||
                    o_result.value !== want.value ||
                    o_result.status !== want.status) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: expected rg=%0d idx=%0d val=%0d st=%0d",
                                 want.region, want.entry_index, want.value, want.status);
                        $display("          actual   rg=%0d idx=%0d val=%0d st=%0d",
                                 o_result.region, o_result.entry_index,
                                 o_result.value, o_result.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no request taken and no result seen.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG) begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        start    = 1'b0;
        cmd      = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        errors   = 0;
        loads_sent = 0;
        reads_sent = 0;
        phases_run = 0;
        idle_pct = 0;
        vtx_reg  = 1;
        edge_reg = 1;
        clear_graph();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset values, single-vertex graph, saturating registers, bad edge.
        add_step('{0, 0, 0, read_cmd(RG_ROOT, 0), 1,
                   mk_result(RG_ROOT, 0, 0, ST_NOT_BUILT)});
        add_step('{0, 0, 0, load_cmd(0, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_OFFSET, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_OFFSET, 1), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_OFFSET, 2), 1,
                   mk_result(RG_OFFSET, 2, 0, ST_RANGE)});
        add_step('{0, 0, 0, read_cmd(RG_NEIGHBOR, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_NEIGHBOR, 4095), 1,
                   mk_result(RG_NEIGHBOR, 4095, 0, ST_RANGE)});
        add_step('{0, 0, 0, read_cmd(RG_ROOT, 77), 1,
                   mk_result(RG_ROOT, 77, 0, ST_OK)});
        add_step('{0, 0, 0, read_cmd(RG_PAIR_CNT, 0), 1,
                   mk_result(RG_PAIR_CNT, 0, 0, ST_OK)});
        add_step('{0, 0, 0, read_cmd(3'd6, 4095), 1,
                   mk_result(3'd6, 4095, 0, ST_RANGE)});
        add_step('{0, 0, 0, read_cmd(3'd7, 0), 1,
                   mk_result(3'd7, 0, 0, ST_RANGE)});
        add_step('{0, 0, 0, read_cmd(RG_PAIR_SRC, 0), 1,
                   mk_result(RG_PAIR_SRC, 0, 0, ST_RANGE)});
        add_step('{0, 0, 0, load_cmd(0, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_NEIGHBOR, 0), 0, '0});
        add_step('{1, REG_VERTEX_COUNT, 0, '0, 0, '0});
        add_step('{0, 0, 0, load_cmd(1, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_OFFSET, 0), 1,
                   mk_result(RG_OFFSET, 0, 0, ST_BAD_EDGE)});
        add_step('{1, REG_VERTEX_COUNT, 2047, '0, 0, '0});
        add_step('{1, REG_EDGE_COUNT, 3, '0, 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_PAIR_CNT, 0), 1,
                   mk_result(RG_PAIR_CNT, 0, 0, ST_NOT_BUILT)});
        add_step('{0, 0, 0, load_cmd(1023, 0), 0, '0});
        add_step('{0, 0, 0, load_cmd(0, 1023), 0, '0});
        add_step('{0, 0, 0, load_cmd(1023, 1023), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_PAIR_SRC, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_PAIR_DST, 0), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_OFFSET, 1024), 0, '0});
        add_step('{0, 0, 0, read_cmd(RG_ROOT, 0), 0, '0});
        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                start <= 1'b0;
                write_reg(steps[i].cfg_reg, steps[i].cfg_val);
            end else begin
                send_request(steps[i].c, steps[i].chk, steps[i].exp);
            end
        end
        start <= 1'b0;

        // Random phases: the sender first idles before 10 requests of a hundred, then before 58.
        while (loads_sent + reads_sent < 300) begin
            idle_pct = (loads_sent + reads_sent < 160) ? 10 : 58;
            random_phase();
        end

        // No gaps from here: a full-size graph of ascending edges that caps
        // the pairs, then a few small graphs.
        idle_pct = 0;
        run_phase(1024, 2100, 1'b0, 100);
        start <= 1'b0;
        repeat (3) random_phase();

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("covered %0d phases: %0d edge loads and %0d reads checked",
                 phases_run, loads_sent, reads_sent);
        $display("including saturated registers, bad edges and the full-size graph");
        if (errors == 0 && pending_reads.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
